/* hdl/pwmppm_pkg.sv */
package pwmppm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PERIOD_MIN  = 3'd0;
  localparam logic [2:0] REG_PERIOD_MAX  = 3'd1;
  localparam logic [2:0] REG_HIGH_MIN    = 3'd2;
  localparam logic [2:0] REG_HIGH_MAX    = 3'd3;
  localparam logic [2:0] REG_FULL_SCALE  = 3'd4;
  localparam logic [2:0] REG_TOUT_MARGIN = 3'd5;

  // Edge flag bit positions
  localparam int unsigned FLAG_RISE  = 0;
  localparam int unsigned FLAG_FALL  = 1;
  localparam int unsigned FLAG_HIGH  = 2;
  localparam int unsigned FLAG_READY = 3;

  // Divide by 1000: shift right by 3, then multiply by ceil(2^36 / 125)
  localparam int unsigned   DIV_PRE_SHIFT = 3;
  localparam int unsigned   DIV_SHIFT     = 36;
  localparam logic [29:0]   DIV_MAGIC     = 30'd549755814;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WAIT = 2'd1,
    ST_DONE = 2'd2,
    ST_FAIL = 2'd3
  } meas_st_t;

  // What the back end does with the held ppm value and reported times
  typedef enum logic [1:0] {
    OP_HOLD     = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_FAIL_SET = 2'd2,
    OP_DONE_SET = 2'd3
  } meas_op_t;

  typedef struct packed {
    logic [15:0] period_min;
    logic [15:0] period_max;
    logic [15:0] high_min;
    logic [15:0] high_max;
    logic [13:0] full_scale;
    logic [15:0] tout_margin;
  } cfg_t;

  typedef struct packed {
    meas_op_t    op;
    meas_st_t    mstate;
    logic [31:0] high_time;
    logic [15:0] low_time;
    logic [15:0] period_time;
  } rec_t;

endpackage

/* hdl/pwmppm_front.sv */
module pwmppm_front import pwmppm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic       action,
  input  logic       pin_level,
  output rec_t       rec
);

  logic        prev_level_r, prev_level_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [31:0] rise_cnt_r, rise_cnt_nxt;
  logic [31:0] fall_cnt_r, fall_cnt_nxt;
  logic [31:0] per_run_r, per_run_nxt;
  logic [31:0] pend_high_r, pend_high_nxt;
  logic [31:0] cap_high_r, cap_high_nxt;
  logic [31:0] cap_low_r, cap_low_nxt;
  logic [31:0] cap_per_r, cap_per_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  meas_st_t    mstate_r, mstate_nxt;
  logic [31:0] rise_inc, fall_inc, per_inc;
  logic [16:0] tout_limit;
  meas_op_t    op;

  assign rise_inc   = rise_cnt_r + 32'd1;
  assign fall_inc   = fall_cnt_r + 32'd1;
  assign per_inc    = per_run_r + 32'd1;
  assign tout_limit = {1'b0, cfg.period_max} + {1'b0, cfg.tout_margin};

  always_comb begin
    prev_level_nxt = prev_level_r;
    flags_nxt      = flags_r;
    rise_cnt_nxt   = rise_cnt_r;
    fall_cnt_nxt   = fall_cnt_r;
    per_run_nxt    = per_run_r;
    pend_high_nxt  = pend_high_r;
    cap_high_nxt   = cap_high_r;
    cap_low_nxt    = cap_low_r;
    cap_per_nxt    = cap_per_r;
    elapsed_nxt    = elapsed_r;
    mstate_nxt     = mstate_r;
    op             = OP_HOLD;
    if (action) begin
      elapsed_nxt = '0;
      mstate_nxt  = ST_WAIT;
      op          = OP_CLEAR;
    end else begin
      rise_cnt_nxt = rise_inc;
      fall_cnt_nxt = fall_inc;
      per_run_nxt  = per_inc;
      elapsed_nxt  = elapsed_r + 32'd1;
      if (pin_level != prev_level_r) begin
        prev_level_nxt = pin_level;
        if (pin_level) begin
          if (flags_r[FLAG_FALL] && flags_r[FLAG_HIGH]) begin
            cap_high_nxt          = pend_high_r;
            cap_low_nxt           = fall_inc;
            cap_per_nxt           = per_inc;
            flags_nxt[FLAG_READY] = 1'b1;
          end
          rise_cnt_nxt         = '0;
          flags_nxt[FLAG_RISE] = 1'b1;
        end else if (flags_r[FLAG_RISE]) begin
          pend_high_nxt        = rise_inc;
          fall_cnt_nxt         = '0;
          per_run_nxt          = rise_inc;
          flags_nxt[FLAG_HIGH] = 1'b1;
          flags_nxt[FLAG_FALL] = 1'b1;
        end
      end
      if (mstate_r == ST_WAIT) begin
        if (flags_nxt[FLAG_READY]) begin
          flags_nxt[FLAG_READY] = 1'b0;
          if (cap_per_nxt < {16'd0, cfg.period_min} ||
              cap_per_nxt > {16'd0, cfg.period_max}) begin
            mstate_nxt = ST_FAIL;
            op         = OP_FAIL_SET;
          end else begin
            mstate_nxt = ST_DONE;
            op         = OP_DONE_SET;
          end
        end else if (elapsed_nxt > {15'd0, tout_limit}) begin
          mstate_nxt = ST_FAIL;
        end
      end
    end
  end

  assign rec.op          = op;
  assign rec.mstate      = mstate_nxt;
  assign rec.high_time   = cap_high_nxt;
  assign rec.low_time    = cap_low_nxt[15:0];
  assign rec.period_time = cap_per_nxt[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      flags_r      <= '0;
      rise_cnt_r   <= '0;
      fall_cnt_r   <= '0;
      per_run_r    <= '0;
      pend_high_r  <= '0;
      cap_high_r   <= '0;
      cap_low_r    <= '0;
      cap_per_r    <= '0;
      elapsed_r    <= '0;
      mstate_r     <= ST_IDLE;
    end else if (take) begin
      prev_level_r <= prev_level_nxt;
      flags_r      <= flags_nxt;
      rise_cnt_r   <= rise_cnt_nxt;
      fall_cnt_r   <= fall_cnt_nxt;
      per_run_r    <= per_run_nxt;
      pend_high_r  <= pend_high_nxt;
      cap_high_r   <= cap_high_nxt;
      cap_low_r    <= cap_low_nxt;
      cap_per_r    <= cap_per_nxt;
      elapsed_r    <= elapsed_nxt;
      mstate_r     <= mstate_nxt;
    end
  end

endmodule

/* hdl/pwmppm_queue.sv */
module pwmppm_queue import pwmppm_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_data,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output rec_t head
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  rec_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/pwmppm_back.sv */
module pwmppm_back import pwmppm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  rec_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_meas_state,
  output logic        out_finished,
  output logic        out_result_valid,
  output logic [15:0] out_co2_ppm,
  output logic [15:0] out_high_time_ms,
  output logic [15:0] out_low_time_ms,
  output logic [15:0] out_period_time_ms
);

  logic        adv;
  logic [31:0] clamped, diff;
  logic [31:0] prod;
  logic [58:0] quot;

  logic        s1_v_r, s2_v_r, s3_v_r, out_v_r;
  rec_t        s1_rec_r, s2_rec_r, s3_rec_r;
  logic [31:0] s1_diff_r;
  logic [31:0] s2_prod_r;
  logic [58:0] s3_quot_r;

  meas_st_t    mstate_r;
  logic [15:0] ppm_r, ppm_nxt;
  logic [15:0] hi_r, hi_nxt;
  logic [15:0] lo_r, lo_nxt;
  logic [15:0] per_r, per_nxt;

  // advance every stage whenever the output slot frees up
  assign adv = !out_v_r || !out_stall;
  assign pop = adv && head_valid;

  always_comb begin
    if (head.high_time < {16'd0, cfg.high_min}) begin
      clamped = {16'd0, cfg.high_min};
    end else if (head.high_time > {16'd0, cfg.high_max}) begin
      clamped = {16'd0, cfg.high_max};
    end else begin
      clamped = head.high_time;
    end
  end

  assign diff = clamped - {16'd0, cfg.high_min};
  assign prod = s1_diff_r * {18'd0, cfg.full_scale};
  assign quot = {30'd0, s2_prod_r[31:DIV_PRE_SHIFT]} * {29'd0, DIV_MAGIC};

  always_comb begin
    ppm_nxt = ppm_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    per_nxt = per_r;
    unique case (s3_rec_r.op)
      OP_HOLD: begin
      end
      OP_CLEAR: begin
        ppm_nxt = '0;
        hi_nxt  = '0;
        lo_nxt  = '0;
        per_nxt = '0;
      end
      OP_FAIL_SET: begin
        hi_nxt  = s3_rec_r.high_time[15:0];
        lo_nxt  = s3_rec_r.low_time;
        per_nxt = s3_rec_r.period_time;
      end
      OP_DONE_SET: begin
        ppm_nxt = s3_quot_r[DIV_SHIFT+15:DIV_SHIFT];
        hi_nxt  = s3_rec_r.high_time[15:0];
        lo_nxt  = s3_rec_r.low_time;
        per_nxt = s3_rec_r.period_time;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      mstate_r <= ST_IDLE;
      ppm_r    <= '0;
      hi_r     <= '0;
      lo_r     <= '0;
      per_r    <= '0;
    end else if (adv) begin
      s1_v_r  <= head_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
      if (s3_v_r) begin
        mstate_r <= s3_rec_r.mstate;
        ppm_r    <= ppm_nxt;
        hi_r     <= hi_nxt;
        lo_r     <= lo_nxt;
        per_r    <= per_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rec_r  <= head;
      s1_diff_r <= diff;
      s2_rec_r  <= s1_rec_r;
      s2_prod_r <= prod;
      s3_rec_r  <= s2_rec_r;
      s3_quot_r <= quot;
    end
  end

  assign out_valid          = out_v_r;
  assign out_meas_state     = mstate_r;
  assign out_finished       = mstate_r[1];
  assign out_result_valid   = (mstate_r == ST_DONE);
  assign out_co2_ppm        = ppm_r;
  assign out_high_time_ms   = hi_r;
  assign out_low_time_ms    = lo_r;
  assign out_period_time_ms = per_r;

endmodule

/* hdl/pwm_pulse_to_ppm_measure.sv */
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_action, in_pin_level
// out_     output     out_valid/out_stall  meas_state, finished, result_valid, co2_ppm,
//                                          high/low/period times
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is accepted per clock while in_stall is low; its result passes through the queue
// slot, then the clamp, full-scale multiply and divide-by-1000 stages, and the result register.
// Reset (rst_n low, synchronous) clears all measurement state and loads default config.
// out_stall freezes the back pipeline; the queue absorbs up to QUEUE_DEPTH items
// before in_stall rises. cfg_ready is always high.
module pwm_pulse_to_ppm_measure import pwmppm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic        in_pin_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_meas_state,
  output logic        out_finished,
  output logic        out_result_valid,
  output logic [15:0] out_co2_ppm,
  output logic [15:0] out_high_time_ms,
  output logic [15:0] out_low_time_ms,
  output logic [15:0] out_period_time_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r;
  logic in_take;
  logic q_full, q_not_empty, q_pop;
  rec_t front_rec, q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_take   = in_valid && !q_full;

  // Config writes take effect at once; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_min  <= 16'd900;
      cfg_r.period_max  <= 16'd1100;
      cfg_r.high_min    <= 16'd2;
      cfg_r.high_max    <= 16'd1002;
      cfg_r.full_scale  <= 14'd5000;
      cfg_r.tout_margin <= 16'd200;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PERIOD_MIN:  cfg_r.period_min  <= cfg_data;
        REG_PERIOD_MAX:  cfg_r.period_max  <= cfg_data;
        REG_HIGH_MIN:    cfg_r.high_min    <= cfg_data;
        REG_HIGH_MAX:    cfg_r.high_max    <= cfg_data;
        REG_FULL_SCALE:  cfg_r.full_scale  <= cfg_data[13:0];
        REG_TOUT_MARGIN: cfg_r.tout_margin <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: edge tracking and the measurement state machine, one item a cycle while in_stall is low.
  pwmppm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .take      (in_take),
    .action    (in_action),
    .pin_level (in_pin_level),
    .rec       (front_rec)
  );

  // Queue: decouple the front from output backpressure.
  pwmppm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (front_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: ppm conversion pipeline and the result register.
  pwmppm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head_valid         (q_not_empty),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_meas_state     (out_meas_state),
    .out_finished       (out_finished),
    .out_result_valid   (out_result_valid),
    .out_co2_ppm        (out_co2_ppm),
    .out_high_time_ms   (out_high_time_ms),
    .out_low_time_ms    (out_low_time_ms),
    .out_period_time_ms (out_period_time_ms)
  );

endmodule

/* test/tb.sv */
module tb;
  import pwmppm_pkg::*;

  // Item kinds on the input channel
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Receiver hold-off length, and quiet cycles after the last reading
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One reading as it leaves the block
  typedef struct packed {
    logic [1:0]  st;
    logic        fin;
    logic        rv;
    logic [15:0] ppm;
    logic [15:0] high_ms;
    logic [15:0] low_ms;
    logic [15:0] per_ms;
  } reading_t;

  // Tracks the decoder state, predicts one reading per item and checks
  // readings in order against it.
  class co2_scoreboard;
    cfg_t        regs;
    logic [31:0] now_ms, rise_ms, fall_ms, pend_high, cap_high, cap_low, open_ms;
    logic        prev_lvl;
    logic [3:0]  flags;
    meas_st_t    mstate;
    logic [15:0] ppm;
    logic        ppm_ok;
    logic [15:0] rep_high, rep_low, rep_period;
    reading_t    expected_q[$];
    int unsigned n_err, n_items, n_starts, n_done, n_fail, n_checked;

    function void reset();
      regs = '{period_min: 16'd900, period_max: 16'd1100, high_min: 16'd2,
               high_max: 16'd1002, full_scale: 14'd5000, tout_margin: 16'd200};
      now_ms = '0; rise_ms = '0; fall_ms = '0; pend_high = '0;
      cap_high = '0; cap_low = '0; open_ms = '0;
      prev_lvl = 1'b0;
      flags = '0;
      mstate = ST_IDLE;
      ppm = '0;
      ppm_ok = 1'b0;
      rep_high = '0; rep_low = '0; rep_period = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_PERIOD_MIN:  regs.period_min  = val;
        REG_PERIOD_MAX:  regs.period_max  = val;
        REG_HIGH_MIN:    regs.high_min    = val;
        REG_HIGH_MAX:    regs.high_max    = val;
        REG_FULL_SCALE:  regs.full_scale  = val[13:0];
        REG_TOUT_MARGIN: regs.tout_margin = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic act, logic lvl);
      logic [31:0] per, h, quot;
      reading_t    r;
      n_items++;
      if (act == ACT_START) begin
        // open a measurement: clear the result, stamp the start time
        ppm = '0;
        ppm_ok = 1'b0;
        rep_high = '0; rep_low = '0; rep_period = '0;
        open_ms = now_ms;
        mstate = ST_WAIT;
        n_starts++;
      end else begin
        now_ms = now_ms + 32'd1;
        // edge detection at the new count
        if (lvl != prev_lvl) begin
          prev_lvl = lvl;
          if (lvl) begin
            if (flags[FLAG_FALL] && flags[FLAG_HIGH]) begin
              cap_high = pend_high;
              cap_low = now_ms - fall_ms;
              flags[FLAG_READY] = 1'b1;
            end
            rise_ms = now_ms;
            flags[FLAG_RISE] = 1'b1;
          end else if (flags[FLAG_RISE]) begin
            pend_high = now_ms - rise_ms;
            fall_ms = now_ms;
            flags[FLAG_HIGH] = 1'b1;
            flags[FLAG_FALL] = 1'b1;
          end
        end
        // advance a waiting measurement; a sample made ready earlier is taken too
        if (mstate == ST_WAIT) begin
          if (flags[FLAG_READY]) begin
            flags[FLAG_READY] = 1'b0;
            per = cap_high + cap_low;
            rep_high = cap_high[15:0];
            rep_low = cap_low[15:0];
            rep_period = per[15:0];
            if (per < 32'(regs.period_min) || per > 32'(regs.period_max)) begin
              ppm_ok = 1'b0;
              mstate = ST_FAIL;
              n_fail++;
            end else begin
              h = cap_high;
              if (h < 32'(regs.high_min))
                h = 32'(regs.high_min);
              else if (h > 32'(regs.high_max))
                h = 32'(regs.high_max);
              // inverted clamps wrap in 32 bits before the divide
              quot = ((h - 32'(regs.high_min)) * 32'(regs.full_scale)) / 32'd1000;
              ppm = quot[15:0];
              ppm_ok = 1'b1;
              mstate = ST_DONE;
              n_done++;
            end
          end else if (now_ms - open_ms >
                       32'(regs.period_max) + 32'(regs.tout_margin)) begin
            ppm_ok = 1'b0;
            mstate = ST_FAIL;
            n_fail++;
          end
        end
      end
      r.st = mstate;
      r.fin = (mstate == ST_DONE) || (mstate == ST_FAIL);
      r.rv = ppm_ok;
      r.ppm = ppm;
      r.high_ms = rep_high;
      r.low_ms = rep_low;
      r.per_ms = rep_period;
      expected_q.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("%0t: reading with nothing expected: st=%0d ppm=%0d", $time,
                   got.st, got.ppm);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_err++;
          if (n_err <= 10) begin
            $display("%0t: mismatch on reading %0d", $time, n_checked);
            $display("  expected st=%0d fin=%0b rv=%0b ppm=%0d hi=%0d lo=%0d per=%0d",
                     want.st, want.fin, want.rv, want.ppm, want.high_ms, want.low_ms,
                     want.per_ms);
            $display("  actual   st=%0d fin=%0b rv=%0b ppm=%0d hi=%0d lo=%0d per=%0d",
                     got.st, got.fin, got.rv, got.ppm, got.high_ms, got.low_ms,
                     got.per_ms);
          end
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic        in_pin_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_meas_state;
  logic        out_finished;
  logic        out_result_valid;
  logic [15:0] out_co2_ppm;
  logic [15:0] out_high_time_ms;
  logic [15:0] out_low_time_ms;
  logic [15:0] out_period_time_ms;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_PERIOD_MIN;
  logic [15:0] cfg_data = 16'd0;

  co2_scoreboard sb = new();

  // Shared with the receiver: quiet stretch flag and hold-off requests
  bit          no_idle = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned n_settings = 0;

  pwm_pulse_to_ppm_measure dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_pin_level       (in_pin_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_meas_state     (out_meas_state),
    .out_finished       (out_finished),
    .out_result_valid   (out_result_valid),
    .out_co2_ppm        (out_co2_ppm),
    .out_high_time_ms   (out_high_time_ms),
    .out_low_time_ms    (out_low_time_ms),
    .out_period_time_ms (out_period_time_ms),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, a quiet stretch on request, and a long hold-off
  // counted here so the sender keeps pushing into a full block.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 36);
    end
  end

  // Monitor: values read here are the ones present before this edge.
  always @(posedge clk) begin
    reading_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.st = out_meas_state;
      got.fin = out_finished;
      got.rv = out_result_valid;
      got.ppm = out_co2_ppm;
      got.high_ms = out_high_time_ms;
      got.low_ms = out_low_time_ms;
      got.per_ms = out_period_time_ms;
      sb.check_reading(got);
    end
  end

  // Offer one item, idling at random first; return once it is taken.
  task automatic send_item(input logic act, input logic lvl);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pin_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(act, lvl);
  endtask

  task automatic ticks(input logic lvl, input int unsigned n);
    repeat (n) send_item(ACT_TICK, lvl);
  endtask

  // Drop valid, wait until every reading is back, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all six registers back to back; hold valid high between writes.
  task automatic program_regs(input cfg_t c);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    idx = '{REG_PERIOD_MIN, REG_PERIOD_MAX, REG_HIGH_MIN, REG_HIGH_MAX,
            REG_FULL_SCALE, REG_TOUT_MARGIN};
    val = '{c.period_min, c.period_max, c.high_min, c.high_max,
            {2'b00, c.full_scale}, c.tout_margin};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Mostly whole PWM periods with random high and low widths, starts
  // dropped in along the way, plus short bursts of random noise items.
  task automatic run_pwm(input int unsigned n_items, input int unsigned max_half);
    int unsigned sent, h, l;
    bit          want_start;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        h = $urandom_range(1, max_half);
        l = $urandom_range(1, max_half);
        for (int unsigned k = 0; k < h + l; k++) begin
          // start often once the last measurement is over, rarely mid-wait
          if (sb.mstate != ST_WAIT)
            want_start = ($urandom_range(0, 9) == 0);
          else
            want_start = ($urandom_range(0, 199) == 0);
          if (want_start) begin
            send_item(ACT_START, 1'($urandom_range(0, 1)));
            sent++;
          end
          send_item(ACT_TICK, k < h);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input cfg_t c, input int unsigned n_items,
                           input int unsigned max_half, input bit squeeze);
    settle();
    program_regs(c);
    // ask the receiver for a long hold-off while items keep coming
    if (squeeze)
      hold_req++;
    run_pwm(n_items, max_half);
  endtask

  initial begin
    cfg_t c;
    sb.reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short window so every outcome shows up in a few items.
    program_regs('{period_min: 16'd3, period_max: 16'd8, high_min: 16'd1,
                   high_max: 16'd3, full_scale: 14'd10000, tout_margin: 16'd0});
    ticks(1'b1, 1);             // rise while idle
    ticks(1'b0, 2);             // fall records the high time
    ticks(1'b1, 1);             // rise makes a sample ready before any start
    send_item(ACT_START, 1'b0);
    ticks(1'b1, 4);             // stale sample taken at once, then done holds
    ticks(1'b0, 1);
    send_item(ACT_START, 1'b1); // pin level ignored on a start
    ticks(1'b0, 1);
    ticks(1'b1, 1);             // high time above the upper clamp
    ticks(1'b0, 1);
    send_item(ACT_START, 1'b0);
    ticks(1'b1, 1);             // period below the window fails
    send_item(ACT_START, 1'b1);
    ticks(1'b1, 9);             // no edges: runs into the timeout

    // Typical window, with the long receiver hold-off
    run_phase('{period_min: 16'd4, period_max: 16'd30, high_min: 16'd2,
                high_max: 16'd12, full_scale: 14'd5000, tout_margin: 16'd6},
              110, 20, 1'b1);
    // Widest window and clamps, largest scale, timeout out of reach
    run_phase('{period_min: 16'd0, period_max: 16'hFFFF, high_min: 16'd0,
                high_max: 16'hFFFF, full_scale: 14'd10000, tout_margin: 16'hFFFF},
              100, 30, 1'b0);
    // Empty window, zero scale, zero margin: every wait fails at once
    run_phase('{period_min: 16'hFFFF, period_max: 16'd0, high_min: 16'hFFFF,
                high_max: 16'd0, full_scale: 14'd0, tout_margin: 16'd0},
              90, 6, 1'b0);
    // Inverted clamps inside an open window
    run_phase('{period_min: 16'd2, period_max: 16'd40, high_min: 16'd15,
                high_max: 16'd3, full_scale: 14'd10000, tout_margin: 16'd3},
              110, 25, 1'b0);
    // Quiet stretch on both sides
    no_idle = 1'b1;
    run_phase('{period_min: 16'd10, period_max: 16'd20, high_min: 16'd1,
                high_max: 16'd8, full_scale: 14'd777, tout_margin: 16'd0},
              100, 12, 1'b0);
    no_idle = 1'b0;
    // Random setting
    c.period_min = 16'($urandom_range(0, 20));
    c.period_max = c.period_min + 16'($urandom_range(0, 30));
    c.high_min = 16'($urandom_range(0, 10));
    c.high_max = 16'($urandom_range(0, 20));
    c.full_scale = 14'($urandom_range(0, 10000));
    c.tout_margin = 16'($urandom_range(0, 10));
    run_phase(c, 110, 20, 1'b0);

    settle();

    $display("Sent %0d items (%0d measurement starts) under %0d register settings.",
             sb.n_items, sb.n_starts, n_settings);
    $display("Checked %0d readings: %0d measurements done, %0d failed or timed out.",
             sb.n_checked, sb.n_done, sb.n_fail);
    if (sb.n_err == 0 && sb.expected_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timed out with %0d readings outstanding.", sb.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
